>>> hw/rtl/ale_pkg.sv
package ale_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int POS_W    = 4;
	localparam int FND_W    = 4;
	localparam int ECNT_W   = 5;
	localparam int VAL_W    = 32;
	localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
	localparam int CEXT_W   = (CNT_W > ECNT_W) ? CNT_W : ECNT_W;
	localparam int FEXT_W   = (IDX_W > FND_W) ? IDX_W : FND_W;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_LOCATE = 2'd2,
		OP_MODIFY = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_POS   = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef struct packed {
		op_t                     operation;
		logic [POS_W-1:0]        position;
		logic signed [VAL_W-1:0] value;
	} ale_req_t;

	typedef struct packed {
		status_t           status;
		logic [FND_W-1:0]  found_position;
		logic [ECNT_W-1:0] entry_count;
	} ale_rsp_t;

endpackage

>>> hw/rtl/ale_ram.sv
module ale_ram (
	input  logic                       clk,
	input  logic [ale_pkg::IDX_W-1:0]  rd_addr,
	output logic [ale_pkg::VAL_W-1:0]  rd_data,
	input  logic                       wr_en,
	input  logic [ale_pkg::IDX_W-1:0]  wr_addr,
	input  logic [ale_pkg::VAL_W-1:0]  wr_data
);
	import ale_pkg::*;

	logic [VAL_W-1:0] mem_q [CAPACITY];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

>>> hw/rtl/array_list_engine_unit.sv
// channel   signals               handshake
// request   start, busy, req      word taken on a clock edge with start high, busy low
// response  done, rsp             word valid for the single cycle done is high
//
// sequencer steps, from the accepting edge to the response, per kind of request
// bad position, full list, empty locate, and delete at the last entry: answered straight from idle
// insert: a read and a move per entry moved up, then a put; modify: a put only
// delete: a read and a move per entry moved down, the last move giving the response
// locate: a read and a compare per entry searched, until a match or the end of the list
// arst_n clears the count and the sequencer; the receiver cannot stall done
module array_list_engine_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  ale_pkg::ale_req_t req,
	output logic              done,
	output ale_pkg::ale_rsp_t rsp
);
	import ale_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_READ = 5'b00010,
		S_MOVE = 5'b00100,
		S_CMP  = 5'b01000,
		S_PUT  = 5'b10000
	} state_t;

	state_t           state_q;
	op_t              op_q;
	logic [IDX_W-1:0] pos_q;
	logic [VAL_W-1:0] val_q;
	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	ale_rsp_t         rsp_q;

	logic [CMP_W-1:0] pos_c;
	logic [CMP_W-1:0] cnt_c;
	logic [CNT_W:0]   idx_p1;
	logic [CNT_W:0]   idx_p2;
	logic [CNT_W:0]   cnt_w;
	logic [IDX_W-1:0] idx_step;
	logic [IDX_W-1:0] rd_addr;
	logic [VAL_W-1:0] rd_data;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [VAL_W-1:0] wr_data;
	logic             accept;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign rsp    = rsp_q;

	assign pos_c    = CMP_W'(req.position);
	assign cnt_c    = CMP_W'(cnt_q);
	assign cnt_w    = (CNT_W+1)'(cnt_q);
	assign idx_p1   = (CNT_W+1)'(idx_q) + (CNT_W+1)'(1);
	assign idx_p2   = (CNT_W+1)'(idx_q) + (CNT_W+1)'(2);
	// shared index step: down for insert, up otherwise
	assign idx_step = (op_q == OP_INSERT) ? idx_q - IDX_W'(1) : idx_q + IDX_W'(1);

	always_comb begin
		rd_addr = idx_q;
		if (op_q == OP_INSERT || op_q == OP_DELETE) begin
			rd_addr = idx_step;
		end
		wr_en   = 1'b0;
		wr_addr = idx_q;
		wr_data = rd_data;
		case (state_q)
			S_MOVE: begin
				wr_en = 1'b1;
			end
			S_PUT: begin
				wr_en   = 1'b1;
				wr_addr = pos_q;
				wr_data = val_q;
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	ale_ram u_ram (
		.clk     (clk),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	function automatic ale_rsp_t make_rsp(status_t st, logic [IDX_W-1:0] fnd,
			logic [CNT_W-1:0] cnt);
		logic [FEXT_W-1:0] f_ext;
		logic [CEXT_W-1:0] c_ext;
		ale_rsp_t          r;
		f_ext            = FEXT_W'(fnd);
		c_ext            = CEXT_W'(cnt);
		r.status         = st;
		r.found_position = f_ext[FND_W-1:0];
		r.entry_count    = c_ext[ECNT_W-1:0];
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (req.operation)
							OP_INSERT: begin
								if (cnt_q >= CNT_W'(CAPACITY)) begin
									done_q <= 1'b1;
									rsp_q  <= make_rsp(ST_FULL, '0, cnt_q);
								end else if (pos_c > cnt_c) begin
									done_q <= 1'b1;
									rsp_q  <= make_rsp(ST_BAD_POS, '0, cnt_q);
								end else begin
									idx_q   <= cnt_q[IDX_W-1:0];
									state_q <= (pos_c == cnt_c) ? S_PUT : S_READ;
								end
							end
							OP_DELETE: begin
								if (pos_c >= cnt_c) begin
									done_q <= 1'b1;
									rsp_q  <= make_rsp(ST_BAD_POS, '0, cnt_q);
								end else if (pos_c + CMP_W'(1) < cnt_c) begin
									idx_q   <= pos_c[IDX_W-1:0];
									state_q <= S_READ;
								end else begin
									cnt_q  <= cnt_q - CNT_W'(1);
									done_q <= 1'b1;
									rsp_q  <= make_rsp(ST_OK, '0, cnt_q - CNT_W'(1));
								end
							end
							OP_LOCATE: begin
								if (cnt_q == '0) begin
									done_q <= 1'b1;
									rsp_q  <= make_rsp(ST_NOT_FOUND, '0, cnt_q);
								end else begin
									idx_q   <= '0;
									state_q <= S_READ;
								end
							end
							default: begin
								if (pos_c >= cnt_c) begin
									done_q <= 1'b1;
									rsp_q  <= make_rsp(ST_BAD_POS, '0, cnt_q);
								end else begin
									state_q <= S_PUT;
								end
							end
						endcase
						op_q  <= req.operation;
						pos_q <= pos_c[IDX_W-1:0];
						val_q <= req.value;
					end
				end
				S_READ: begin
					state_q <= (op_q == OP_LOCATE) ? S_CMP : S_MOVE;
				end
				S_MOVE: begin
					idx_q <= idx_step;
					if (op_q == OP_INSERT) begin
						state_q <= (idx_step == pos_q) ? S_PUT : S_READ;
					end else if (idx_p2 < cnt_w) begin
						state_q <= S_READ;
					end else begin
						state_q <= S_IDLE;
						cnt_q   <= cnt_q - CNT_W'(1);
						done_q  <= 1'b1;
						rsp_q   <= make_rsp(ST_OK, '0, cnt_q - CNT_W'(1));
					end
				end
				S_CMP: begin
					if (rd_data == val_q) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
						rsp_q   <= make_rsp(ST_OK, idx_q, cnt_q);
					end else if (idx_p1 < cnt_w) begin
						idx_q   <= idx_step;
						state_q <= S_READ;
					end else begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
						rsp_q   <= make_rsp(ST_NOT_FOUND, '0, cnt_q);
					end
				end
				S_PUT: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
					if (op_q == OP_INSERT) begin
						cnt_q <= cnt_q + CNT_W'(1);
						rsp_q <= make_rsp(ST_OK, '0, cnt_q + CNT_W'(1));
					end else begin
						rsp_q <= make_rsp(ST_OK, '0, cnt_q);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !wr_en)
		else $error("list memory written while idle");

	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q != S_IDLE || start))
		else $error("response without a request in flight");

	a_locate_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && op_q == OP_LOCATE) |-> $stable(cnt_q))
		else $error("locate changed the entry count");

endmodule
